// ----- hdl/pfa_pkg.sv -----
package pfa_pkg;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_NEG = 3'd4;
  localparam logic [2:0] OP_INV = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DIV = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  localparam logic [31:0] MODULUS_RESET = 32'd65537;

  typedef struct packed {
    logic [2:0]  operation;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
  } in_t;

  typedef struct packed {
    logic [31:0] result;
    logic [1:0]  status;
  } out_t;

endpackage

// ----- hdl/pfa_mulmod.sv -----
module pfa_mulmod #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] x,
  input  logic [WIDTH-1:0] y,
  input  logic [WIDTH-1:0] p,
  output logic             done,
  output logic [WIDTH-1:0] prod
);

  localparam int CW = $clog2(WIDTH);

  logic [WIDTH-1:0] x_r;
  logic [WIDTH-1:0] y_r;
  logic [WIDTH-1:0] p_r;
  logic [WIDTH-1:0] acc_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [WIDTH-1:0] dbl;
  logic [WIDTH-1:0] acc_nxt;

  function automatic logic [WIDTH-1:0] mod_add(
    input logic [WIDTH-1:0] s,
    input logic [WIDTH-1:0] t,
    input logic [WIDTH-1:0] m
  );
    logic [WIDTH:0] sum;
    sum = {1'b0, s} + {1'b0, t};
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
    return sum[WIDTH-1:0];
  endfunction

  always_comb begin
    dbl     = mod_add(acc_r, acc_r, p_r);
    acc_nxt = y_r[WIDTH-1] ? mod_add(dbl, x_r, p_r) : dbl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= x;
        y_r    <= y;
        p_r    <= p;
        acc_r  <= '0;
        cnt_r  <= CW'(WIDTH - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        y_r   <= {y_r[WIDTH-2:0], 1'b0};
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ----- hdl/prime_field_alu_top.sv -----
// Arithmetic unit over GF(p), p held in a 32-bit register (low WIDTH bits used).
// Input channel in_valid/in_ready carries operation, operand_a, operand_b;
// output channel out_valid/out_ready carries one result and status per item.
// The user must write the modulus register by cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
// Work per accepted item:
//   add, subtract, negate and every error case: result registered on acceptance.
//   multiply: done by the bit-serial modular multiplier
//     that consumes one multiplier bit per cycle.
//   inverse: one squaring per
//     exponent bit plus one multiply per set bit of p - 2.
//   divide: the inverse steps, then a final multiply.
// One item is in work at a time; in_ready is high only between items.
// A finished result sits in the output register while the next item is
// accepted; if that result is still not taken when the next one finishes,
// the block holds and in_ready stays low.
// Synchronous reset clears the control state and loads the modulus 65537.
module prime_field_alu_top #(
  parameter int WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  pfa_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pfa_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data
);

  import pfa_pkg::*;

  localparam int CW = $clog2(WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ,
    S_ML,
    S_NEXT,
    S_FM,
    S_FIN
  } state_t;

  state_t           state_r;
  logic [31:0]      cfg_r;
  logic [2:0]       op_r;
  logic [WIDTH-1:0] a_r;
  logic [WIDTH-1:0] x_r;
  logic [WIDTH-1:0] e_r;
  logic [CW-1:0]    cnt_r;
  logic [WIDTH-1:0] res_r;
  logic [1:0]       st_r;
  logic             out_valid_r;
  out_t             out_data_r;
  logic             mul_go_r;
  logic [WIDTH-1:0] mul_x_r;
  logic [WIDTH-1:0] mul_y_r;
  logic             mul_done;
  logic [WIDTH-1:0] mul_prod;

  logic [95:0]       a_ext;
  logic [95:0]       b_ext;
  logic [95:0]       m_ext;
  logic [WIDTH+63:0] p_ext;
  logic [WIDTH+31:0] res_ext;
  logic [WIDTH-1:0]  a_w;
  logic [WIDTH-1:0]  b_w;
  logic [WIDTH-1:0]  p_w;
  logic [WIDTH-1:0]  r_init;
  logic              a_big;
  logic              b_big;

  function automatic logic [WIDTH-1:0] mod_add(
    input logic [WIDTH-1:0] s,
    input logic [WIDTH-1:0] t,
    input logic [WIDTH-1:0] m
  );
    logic [WIDTH:0] sum;
    sum = {1'b0, s} + {1'b0, t};
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
    return sum[WIDTH-1:0];
  endfunction

  function automatic logic [WIDTH-1:0] mod_sub(
    input logic [WIDTH-1:0] s,
    input logic [WIDTH-1:0] t,
    input logic [WIDTH-1:0] m
  );
    logic [WIDTH-1:0] d;
    if (s >= t) begin
      d = s - t;
    end else begin
      d = m - (t - s);
    end
    return d;
  endfunction

  always_comb begin
    a_ext   = {64'b0, in_data.operand_a};
    b_ext   = {64'b0, in_data.operand_b};
    m_ext   = {64'b0, cfg_r};
    a_w     = a_ext[WIDTH-1:0];
    b_w     = b_ext[WIDTH-1:0];
    p_w     = m_ext[WIDTH-1:0];
    p_ext   = {64'b0, p_w};
    a_big   = a_ext[63:0] >= p_ext[63:0];
    b_big   = b_ext[63:0] >= p_ext[63:0];
    r_init  = (p_w >= WIDTH'(2)) ? WIDTH'(1) : '0;
    res_ext = {32'b0, res_r};
  end

  pfa_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mul_go_r),
    .x    (mul_x_r),
    .y    (mul_y_r),
    .p    (p_w),
    .done (mul_done),
    .prod (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_r       <= MODULUS_RESET;
      out_valid_r <= 1'b0;
      mul_go_r    <= 1'b0;
    end else begin
      mul_go_r <= 1'b0;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r  <= in_data.operation;
            a_r   <= a_w;
            x_r   <= (in_data.operation == OP_DIV) ? b_w : a_w;
            e_r   <= p_w - WIDTH'(2);
            cnt_r <= CW'(WIDTH - 1);
            res_r <= '0;
            st_r  <= ST_OK;
            state_r <= S_FIN;
            unique case (in_data.operation)
              OP_ADD: begin
                if (a_big || b_big) begin
                  st_r <= ST_RANGE;
                end else begin
                  res_r <= mod_add(a_w, b_w, p_w);
                end
              end
              OP_SUB: begin
                if (a_big || b_big) begin
                  st_r <= ST_RANGE;
                end else begin
                  res_r <= mod_sub(a_w, b_w, p_w);
                end
              end
              OP_NEG: begin
                if (a_big) begin
                  st_r <= ST_RANGE;
                end else begin
                  res_r <= mod_sub('0, a_w, p_w);
                end
              end
              OP_MUL: begin
                if (a_big || b_big) begin
                  st_r <= ST_RANGE;
                end else begin
                  mul_x_r  <= a_w;
                  mul_y_r  <= b_w;
                  mul_go_r <= 1'b1;
                  state_r  <= S_FM;
                end
              end
              OP_DIV: begin
                priority if (a_big || b_big) begin
                  st_r <= ST_RANGE;
                end else if (b_w == '0) begin
                  st_r <= ST_ZERO_DIV;
                end else begin
                  mul_x_r  <= r_init;
                  mul_y_r  <= r_init;
                  mul_go_r <= 1'b1;
                  state_r  <= S_SQ;
                end
              end
              OP_INV: begin
                priority if (a_big) begin
                  st_r <= ST_RANGE;
                end else if (a_w == '0) begin
                  st_r <= ST_ZERO_DIV;
                end else begin
                  mul_x_r  <= r_init;
                  mul_y_r  <= r_init;
                  mul_go_r <= 1'b1;
                  state_r  <= S_SQ;
                end
              end
              default: begin
                st_r <= ST_RANGE;
              end
            endcase
          end
        end
        S_SQ: begin
          if (mul_done) begin
            if (e_r[WIDTH-1]) begin
              mul_x_r  <= mul_prod;
              mul_y_r  <= x_r;
              mul_go_r <= 1'b1;
              state_r  <= S_ML;
            end else begin
              state_r <= S_NEXT;
            end
          end
        end
        S_ML: begin
          if (mul_done) begin
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (cnt_r == '0) begin
            if (op_r == OP_DIV) begin
              mul_x_r  <= a_r;
              mul_y_r  <= mul_prod;
              mul_go_r <= 1'b1;
              state_r  <= S_FM;
            end else begin
              res_r   <= mul_prod;
              state_r <= S_FIN;
            end
          end else begin
            cnt_r    <= cnt_r - 1'b1;
            e_r      <= {e_r[WIDTH-2:0], 1'b0};
            mul_x_r  <= mul_prod;
            mul_y_r  <= mul_prod;
            mul_go_r <= 1'b1;
            state_r  <= S_SQ;
          end
        end
        S_FM: begin
          if (mul_done) begin
            res_r   <= mul_prod;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_data_r.result <= res_ext[31:0];
            out_data_r.status <= st_r;
            out_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/pfa_checker.sv -----
module pfa_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input pfa_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input pfa_pkg::out_t out_data
);

  import pfa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ST_OK || out_data.status == ST_ZERO_DIV ||
                   out_data.status == ST_RANGE))
    else $error("undefined status code");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.result == 32'd0)
    else $error("error status with nonzero result");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("input transaction dropped or changed while waiting");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind prime_field_alu_top pfa_checker u_pfa_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ----- sim/field_result_checker.sv -----
module field_result_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  pfa_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  pfa_pkg::out_t out_data,
  input  logic          cfg_wr_en,
  input  logic [31:0]   cfg_wr_data,
  output int            mismatches,
  output int            in_flight
);

  import pfa_pkg::*;

  logic [31:0] modulus;
  out_t        expected_results[$];
  out_t        want;
  int          err_cnt = 0;

  function automatic logic [63:0] field_pow(input logic [63:0] base, input logic [63:0] e,
                                            input logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    logic [63:0] k;
    acc = 64'd1 % m;
    sq = base;
    k = e;
    while (k != 0) begin
      if (k[0]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
      k = k >> 1;
    end
    return acc;
  endfunction

  function automatic out_t field_result(input in_t item, input logic [31:0] p);
    out_t        r;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] m;
    logic        uses_b;
    r.result = '0;
    r.status = ST_OK;
    a = 64'(item.operand_a);
    b = 64'(item.operand_b);
    m = 64'(p);
    uses_b = (item.operation <= OP_DIV);
    if (item.operation > OP_INV) begin
      r.status = ST_RANGE;
    end else if (a >= m || (uses_b && b >= m)) begin
      r.status = ST_RANGE;
    end else begin
      case (item.operation)
        OP_ADD: r.result = 32'((a + b) % m);
        OP_SUB: r.result = 32'((a + m - b) % m);
        OP_MUL: r.result = 32'((a * b) % m);
        OP_NEG: r.result = 32'((m - a) % m);
        OP_INV: begin
          if (a == 0) r.status = ST_ZERO_DIV;
          else r.result = 32'(field_pow(a, m - 2, m));
        end
        default: begin
          if (b == 0) r.status = ST_ZERO_DIV;
          else r.result = 32'((a * field_pow(b, m - 2, m)) % m);
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      modulus = MODULUS_RESET;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected transaction: result %0d status %0d",
                 out_data.result, out_data.status);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.result !== want.result) begin
            $error("result: expected %0d, got %0d", want.result, out_data.result);
            err_cnt++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(field_result(in_data, modulus));
      if (cfg_wr_en) modulus = cfg_wr_data;
    end
    mismatches <= err_cnt;
    in_flight <= expected_results.size();
  end

endmodule

// ----- sim/tb.sv -----
module tb;
  import pfa_pkg::*;

  localparam logic [2:0] OP_RSVD_A = 3'd6;
  localparam logic [2:0] OP_RSVD_B = 3'd7;
  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int PHASE_ITEMS = 250;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_t         in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  int          mismatches;
  int          in_flight;
  int          cycles = 0;
  int          stall_clk = 0;
  int          stall_pct = 0;
  logic [31:0] cur_p;
  int          left;
  int          burst;
  int          gap;
  logic [31:0] phase_mod [8] = '{32'd3, 32'd4294967291, 32'd4294967295, 32'd65537,
                                 32'd2147483647, 32'd251, 32'd0, 32'd5};

  prime_field_alu_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  field_result_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // vary the stall rate during the run, including stretches with no stalls
  always @(posedge clk) begin
    stall_clk <= stall_clk + 1;
    if (stall_clk % 512 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 30;
        2: stall_pct <= 60;
        default: stall_pct <= 85;
      endcase
    end
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic in_t pack_item(input logic [2:0] op, input logic [31:0] a,
                                    input logic [31:0] b);
    in_t it;
    it.operation = op;
    it.operand_a = a;
    it.operand_b = b;
    return it;
  endfunction

  function automatic logic [31:0] field_operand(input logic [31:0] p);
    logic [63:0] span;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) return 32'd0;
    if (pick < 16) return 32'd1;
    if (pick < 26) return p - 32'd1;
    if (pick < 31) begin
      span = 64'h1_0000_0000 - p;
      return 32'(p + ($urandom % span));
    end
    return $urandom % p;
  endfunction

  function automatic in_t random_item(input logic [31:0] p);
    in_t         it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.operand_a = field_operand(p);
    it.operand_b = field_operand(p);
    if (pick < 22) begin
      it.operation = OP_ADD;
    end else if (pick < 44) begin
      it.operation = OP_SUB;
    end else if (pick < 70) begin
      it.operation = OP_MUL;
    end else if (pick < 86) begin
      it.operation = OP_NEG;
      it.operand_b = $urandom;
    end else if (pick < 91) begin
      it.operation = OP_DIV;
    end else if (pick < 96) begin
      it.operation = OP_INV;
      it.operand_b = $urandom;
    end else begin
      it.operation = $urandom_range(0, 1) ? OP_RSVD_A : OP_RSVD_B;
      it.operand_a = $urandom;
      it.operand_b = $urandom;
    end
    return it;
  endfunction

  task automatic send(input in_t item);
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  task automatic load_modulus(input logic [31:0] p);
    in_valid <= 1'b0;
    drain();
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_p = p;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    cur_p = MODULUS_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    send(pack_item(OP_ADD, 32'd0, 32'd0));
    send(pack_item(OP_ADD, cur_p - 1, cur_p - 1));
    send(pack_item(OP_ADD, cur_p - 1, 32'd1));
    send(pack_item(OP_SUB, 32'd0, cur_p - 1));
    send(pack_item(OP_SUB, 32'd12345, 32'd12345));
    send(pack_item(OP_MUL, cur_p - 1, cur_p - 1));
    send(pack_item(OP_MUL, 32'd0, 32'd54321));
    send(pack_item(OP_NEG, 32'd0, 32'hFFFF_FFFF));
    send(pack_item(OP_NEG, cur_p - 1, 32'd0));
    send(pack_item(OP_INV, 32'd1, 32'd0));
    send(pack_item(OP_INV, 32'd0, 32'd7));
    send(pack_item(OP_INV, cur_p - 1, 32'hFFFF_FFFF));
    send(pack_item(OP_INV, 32'd3, 32'd0));
    send(pack_item(OP_DIV, 32'd100, 32'd0));
    send(pack_item(OP_DIV, cur_p - 1, cur_p - 1));
    send(pack_item(OP_DIV, 32'd0, 32'd3));
    send(pack_item(OP_DIV, 32'd7, 32'd3));
    send(pack_item(OP_ADD, cur_p, 32'd0));
    send(pack_item(OP_MUL, 32'd1, cur_p));
    send(pack_item(OP_INV, 32'hFFFF_FFFF, 32'd0));
    send(pack_item(OP_DIV, cur_p, 32'd0));
    send(pack_item(OP_RSVD_A, $urandom, $urandom));
    send(pack_item(OP_RSVD_B, 32'd0, 32'd0));

    phase_mod[6] = $urandom | 32'h0000_0101;
    for (int ph = 0; ph < 8; ph++) begin
      load_modulus(phase_mod[ph]);
      left = PHASE_ITEMS;
      while (left > 0) begin
        burst = $urandom_range(1, 16);
        while (burst > 0 && left > 0) begin
          send(random_item(cur_p));
          burst--;
          left--;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- prime_field_alu_top.f -----
hdl/pfa_pkg.sv
hdl/pfa_mulmod.sv
hdl/prime_field_alu_top.sv
hdl/pfa_checker.sv
sim/field_result_checker.sv
sim/tb.sv
